// File: rtl/spr_pkg.sv
package spr_pkg;

  localparam int unsigned SHIFT_W = 40;
  localparam int unsigned WORD_W  = 64;

  localparam logic [60:0] PRIME61   = {61{1'b1}};
  localparam logic [63:0] PRIME61_W = {3'b000, {61{1'b1}}};

  localparam logic [1:0] REG_TERM_COUNT = 2'd0;
  localparam logic [1:0] REG_MULTIPLIER = 2'd1;
  localparam logic [1:0] REG_INV_THETA  = 2'd2;

  typedef struct packed {
    logic [5:0]  term_count;
    logic [63:0] multiplier;
    logic [63:0] inv_theta;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic               valid;
    logic [SHIFT_W-1:0] shift_echo;
    logic [63:0]        start_n;
    logic               is_hit;
    logic               overlap_region;
    logic               last;
  } res_t;

  // 64-bit value reduced mod 2^61-1
  function automatic logic [60:0] red64(input logic [63:0] x);
    logic [63:0] r;
    r = {3'b000, x[60:0]} + {61'd0, x[63:61]};
    if (r >= PRIME61_W) r = r - PRIME61_W;
    return r[60:0];
  endfunction

  // fold of a full product, one conditional subtract
  function automatic logic [63:0] fold_prod(input logic [127:0] p);
    logic [64:0] s;
    s = {4'd0, p[60:0]} + {1'b0, p[124:61]};
    if (s >= {1'b0, PRIME61_W}) s = s - {1'b0, PRIME61_W};
    return s[63:0];
  endfunction

  function automatic logic [60:0] inc61(input logic [60:0] x);
    return (x == PRIME61 - 61'd1) ? 61'd0 : x + 61'd1;
  endfunction

  function automatic logic [60:0] add61(input logic [60:0] a, input logic [60:0] b);
    logic [61:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, PRIME61}) s = s - {1'b0, PRIME61};
    return s[60:0];
  endfunction

endpackage

// File: rtl/spr_mul.sv
module spr_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  spr_pkg::mul_req_t req_i,
  output spr_pkg::mul_rsp_t rsp_o
);

  localparam logic [2:0] STEP_LAST = 3'd4;

  logic         run_q, done_q;
  logic [2:0]   step_q;
  logic [63:0]  a_q, b_q, pp_q;
  logic [1:0]   ps_q;
  logic [127:0] acc_q;
  logic [31:0]  ah, bh;
  logic [63:0]  pp;
  logic [127:0] addend;

  // partial product order: lo*lo, lo*hi, hi*lo, hi*hi
  assign ah     = step_q[1] ? a_q[63:32] : a_q[31:0];
  assign bh     = step_q[0] ? b_q[63:32] : b_q[31:0];
  assign pp     = ah * bh;
  assign addend = {64'd0, pp_q} << {ps_q, 5'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= 3'd0;
    end else if (req_i.start) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      step_q <= 3'd0;
    end else if (run_q) begin
      step_q <= step_q + 3'd1;
      if (step_q == STEP_LAST) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      acc_q <= '0;
    end else if (run_q) begin
      if (!step_q[2]) begin
        pp_q <= pp;
        ps_q <= {1'b0, step_q[1]} + {1'b0, step_q[0]};
      end
      if (step_q != 3'd0) acc_q <= acc_q + addend;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

endmodule

// File: rtl/spr_seq.sv
module spr_seq #(
  parameter int unsigned MAX_TERMS  = 32,
  parameter int unsigned SHIFT_BITS = 40
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [spr_pkg::SHIFT_W-1:0]  shift_d_i,
  input  spr_pkg::cfg_t                cfg_i,
  output logic                         busy_o,
  output spr_pkg::res_t                res_o,
  output spr_pkg::mul_req_t            mul_req_o,
  input  spr_pkg::mul_rsp_t            mul_rsp_i
);

  localparam int unsigned SPAN_W = $clog2(MAX_TERMS + 5);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_BASE   = 4'd1;
  localparam logic [3:0] S_WIN1   = 4'd2;
  localparam logic [3:0] S_WIN2   = 4'd3;
  localparam logic [3:0] S_NSTART = 4'd4;
  localparam logic [3:0] S_STEP   = 4'd5;
  localparam logic [3:0] S_LWAIT  = 4'd6;
  localparam logic [3:0] S_RWAIT  = 4'd7;
  localparam logic [3:0] S_CMP    = 4'd8;
  localparam logic [3:0] S_LAST   = 4'd9;

  logic [3:0]             state_q, state_d;
  logic [SHIFT_BITS-1:0]  d_q, d_in;
  logic [5:0]             k_q, k_in, i_q;
  logic                   ovl_q;
  logic [60:0]            nmod_q, nm_q, fa_q, fb_q;
  logic [63:0]            base_q, nlo_q, nhi_q, n_q, lhs_q, rhs_q, kp2;
  logic [SPAN_W-1:0]      j_q, span_q;
  logic                   valid_q, shot;
  logic [spr_pkg::SHIFT_W-1:0] echo_q;
  logic [63:0]            rn_q;
  logic                   rhit_q, rovl_q, rlast_q;
  logic                   match;

  assign d_in  = shift_d_i[SHIFT_BITS-1:0];
  assign k_in  = (cfg_i.term_count > 6'(MAX_TERMS)) ? 6'(MAX_TERMS) : cfg_i.term_count;
  assign kp2   = 64'(k_q) + 64'd2;
  assign match = (lhs_q == rhs_q);
  assign shot  = (state_q == S_IDLE) && start_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (start_i) state_d = S_BASE;
      S_BASE:   if (mul_rsp_i.done) state_d = S_WIN1;
      S_WIN1:   state_d = S_WIN2;
      S_WIN2:   state_d = S_NSTART;
      S_NSTART: state_d = S_STEP;
      S_STEP:   state_d = (i_q == k_q) ? S_CMP : S_LWAIT;
      S_LWAIT:  if (mul_rsp_i.done) state_d = S_RWAIT;
      S_RWAIT:  if (mul_rsp_i.done) state_d = S_STEP;
      S_CMP:    state_d = (j_q == span_q) ? S_LAST : S_NSTART;
      S_LAST:   state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    mul_req_o = '0;
    unique case (state_q)
      S_IDLE: begin
        mul_req_o.start = start_i;
        mul_req_o.a     = 64'(d_in);
        mul_req_o.b     = cfg_i.inv_theta;
      end
      S_STEP: begin
        mul_req_o.start = (i_q != k_q);
        mul_req_o.a     = lhs_q;
        mul_req_o.b     = 64'(spr_pkg::inc61(fa_q));
      end
      S_LWAIT: begin
        mul_req_o.start = mul_rsp_i.done;
        mul_req_o.a     = rhs_q;
        mul_req_o.b     = 64'(fb_q);
      end
      default: mul_req_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= ((state_q == S_CMP) && match) || (state_q == S_LAST);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          d_q    <= d_in;
          k_q    <= k_in;
          ovl_q  <= (64'(d_in) < 64'(k_in));
          nmod_q <= spr_pkg::red64(cfg_i.multiplier);
        end
      end
      S_BASE: if (mul_rsp_i.done) base_q <= mul_rsp_i.prod[103:40];
      S_WIN1: begin
        nlo_q <= (base_q >= kp2) ? base_q - kp2 : 64'd0;
        nhi_q <= (base_q > 64'hFFFF_FFFF_FFFF_FFFD) ? '1 : base_q + 64'd2;
      end
      S_WIN2: begin
        span_q <= SPAN_W'(nhi_q - nlo_q);
        n_q    <= nlo_q;
        nm_q   <= spr_pkg::red64(nlo_q);
        j_q    <= '0;
      end
      S_NSTART: begin
        lhs_q <= 64'd1;
        rhs_q <= 64'(nmod_q);
        fa_q  <= spr_pkg::add61(nm_q, 61'(d_q));
        fb_q  <= nm_q;
        i_q   <= 6'd0;
      end
      S_STEP: begin
        if (i_q != k_q) begin
          fa_q <= spr_pkg::inc61(fa_q);
          fb_q <= spr_pkg::inc61(fb_q);
        end
      end
      S_LWAIT: if (mul_rsp_i.done) lhs_q <= spr_pkg::fold_prod(mul_rsp_i.prod);
      S_RWAIT: begin
        if (mul_rsp_i.done) begin
          rhs_q <= spr_pkg::fold_prod(mul_rsp_i.prod);
          i_q   <= i_q + 6'd1;
        end
      end
      S_CMP: begin
        if (match) begin
          echo_q  <= spr_pkg::SHIFT_W'(d_q);
          rn_q    <= n_q;
          rhit_q  <= 1'b1;
          rovl_q  <= ovl_q;
          rlast_q <= 1'b0;
        end
        if (j_q != span_q) begin
          n_q  <= n_q + 64'd1;
          nm_q <= spr_pkg::inc61(nm_q);
          j_q  <= j_q + SPAN_W'(1);
        end
      end
      S_LAST: begin
        echo_q  <= spr_pkg::SHIFT_W'(d_q);
        rn_q    <= 64'd0;
        rhit_q  <= 1'b0;
        rovl_q  <= ovl_q;
        rlast_q <= 1'b1;
      end
      default: ;
    endcase
  end

  assign busy_o               = (state_q != S_IDLE);
  assign res_o.valid          = valid_q;
  assign res_o.shift_echo     = echo_q;
  assign res_o.start_n        = rn_q;
  assign res_o.is_hit         = rhit_q;
  assign res_o.overlap_region = rovl_q;
  assign res_o.last           = rlast_q;

  a_shot_to_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shot |=> (state_q == S_BASE))
    else $error("accepted word did not start base product");

  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LAST) |=> (valid_q && rlast_q && !rhit_q && state_q == S_IDLE))
    else $error("closing word malformed");

  a_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp_i.done |-> (state_q == S_BASE || state_q == S_LWAIT || state_q == S_RWAIT))
    else $error("multiplier result with no waiting state");

  a_window_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> (j_q <= span_q && i_q == k_q))
    else $error("window or term counter out of range");

endmodule

// File: rtl/shifted_product_ratio_check_top.sv
// One shift word is taken when start_i is high and busy_o is low; busy_o then stays high until
// the shift is done. Each match comes out as a one-cycle valid_o strobe with is_hit_o set, in
// increasing start_n_o, followed by one closing word with last_o set; the receiver cannot stall,
// so every strobed word must be taken in its cycle. All products run on one shared 32x32
// multiplier that needs four partial products plus accumulation per 64-bit product. A shift
// checks W+1 window values, each over k terms of two products, where k is the saturated term
// count and W+1 <= k+5.
// Registers sit on a 64-bit APB port: term_count at 0x00, multiplier at 0x08, inv_theta at 0x10.
module shifted_product_ratio_check_top #(
  parameter int unsigned MAX_TERMS  = 32,
  parameter int unsigned SHIFT_BITS = 40
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [4:0]                  paddr,
  input  logic [63:0]                 pwdata,
  output logic [63:0]                 prdata,
  output logic                        pready,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [spr_pkg::SHIFT_W-1:0] shift_d_i,
  output logic                        valid_o,
  output logic [spr_pkg::SHIFT_W-1:0] shift_echo_o,
  output logic [63:0]                 start_n_o,
  output logic                        is_hit_o,
  output logic                        overlap_region_o,
  output logic                        last_o
);

  spr_pkg::cfg_t     cfg_q;
  spr_pkg::res_t     res;
  spr_pkg::mul_req_t mul_req;
  spr_pkg::mul_rsp_t mul_rsp;
  logic              wr;
  logic [1:0]        idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[4:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.term_count <= 6'd1;
      cfg_q.multiplier <= 64'd1;
      cfg_q.inv_theta  <= 64'd0;
    end else if (wr) begin
      unique case (idx)
        spr_pkg::REG_TERM_COUNT: cfg_q.term_count <= pwdata[5:0];
        spr_pkg::REG_MULTIPLIER: cfg_q.multiplier <= pwdata;
        spr_pkg::REG_INV_THETA:  cfg_q.inv_theta  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      spr_pkg::REG_TERM_COUNT: prdata = 64'(cfg_q.term_count);
      spr_pkg::REG_MULTIPLIER: prdata = cfg_q.multiplier;
      spr_pkg::REG_INV_THETA:  prdata = cfg_q.inv_theta;
      default:                 prdata = 64'd0;
    endcase
  end

  spr_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  spr_seq #(
    .MAX_TERMS  (MAX_TERMS),
    .SHIFT_BITS (SHIFT_BITS)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .shift_d_i (shift_d_i),
    .cfg_i     (cfg_q),
    .busy_o    (busy_o),
    .res_o     (res),
    .mul_req_o (mul_req),
    .mul_rsp_i (mul_rsp)
  );

  assign valid_o          = res.valid;
  assign shift_echo_o     = res.shift_echo;
  assign start_n_o        = res.start_n;
  assign is_hit_o         = res.is_hit;
  assign overlap_region_o = res.overlap_region;
  assign last_o           = res.last;

endmodule
